// ===== rtl/tcdb_pkg.sv =====
// Package for the text console display buffer.
// Holds geometry defaults, control byte codes and status codes; no dependencies.
package tcdb_pkg;
    localparam int MAX_COLUMNS_DEF = 64;
    localparam int MAX_ROWS_DEF    = 32;
    localparam int TAB_STOP_DEF    = 8;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [6:0] CH_SPACE = 7'h20;

    localparam logic [6:0] WIDTH_RESET  = 7'd40;
    localparam logic [5:0] HEIGHT_RESET = 6'd16;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_READ = 2'd1;
    localparam logic [1:0] ST_BAD_WRITE = 2'd2;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;
endpackage

// ===== rtl/text_console_display_buffer_unit.sv =====
// Top level of the text console display buffer.
// Depends on tcdb_pkg; holds the cell memory and its byte sequencer.
//
// Usage: requests (op, address, data_byte) enter on in_valid/in_ready; one
// result per request leaves on out_valid/out_ready. A read or a bad address
// goes straight to the result; a direct cell write passes S_PUT. A printable
// byte is written in S_PUT, a tab writes spaces up to the next tab stop and
// LF clears the rest of the line; these, CR, BS and ignored bytes then run the
// wrap check. A form feed clears the whole screen. The sequencer touches one
// cell per cycle through a write port and a registered read port. A wrap to a
// fresh line clears that line; a scroll reads each cell and writes it one row
// up, then clears the last row. in_ready is low while a request is in work
// and while the result waits; the next request can be taken in the cycle
// after the result transfer. Reset: a clearing pass writes spaces to all
// MAX_COLUMNS*MAX_ROWS cells, one a cycle, before the first transfer is taken;
// configuration writes are taken at any time. A register write homes the
// cursor unless the sequencer moves it in that cycle. When the receiver stalls,
// the result holds in the output register and no new request is taken.
module text_console_display_buffer_unit #(
    parameter int MAX_COLUMNS = tcdb_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = tcdb_pkg::MAX_ROWS_DEF,
    parameter int TAB_STOP    = tcdb_pkg::TAB_STOP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [6:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [11:0] address,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [22:0] read_data,
    output logic [1:0]  status,
    output logic        refresh_valid,
    output logic [4:0]  refresh_first,
    output logic [5:0]  refresh_last
);
    import tcdb_pkg::*;

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CW    = $clog2(MAX_COLUMNS + 1);
    localparam int RW    = $clog2(MAX_ROWS + 1);
    localparam int IW    = AW + 1;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLEAR, S_PUT, S_TAB, S_WRAP, S_SCR_RD, S_SCR_WR,
        S_SCR_CLR, S_DONE, S_OUT
    } state_t;

    state_t state_reg;
    logic [6:0]  width_reg;
    logic [5:0]  height_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [IW-1:0] ptr_reg;
    logic [IW-1:0] end_reg;
    logic [6:0]  byte_reg;
    logic [6:0]  rd_reg;
    logic        upd_reg;
    logic [RW-1:0] lo_reg;
    logic [RW-1:0] hi_reg;
    // after a clear, 1 ends the request and 0 runs the wrap check;
    // in S_PUT, 1 marks a direct cell write
    logic        lf_reg;
    logic [22:0] rdata_reg;
    logic [1:0]  status_reg;
    logic [6:0]  mem [CELLS];

    // effective geometry
    logic [CW-1:0] w;
    logic [RW-1:0] h;
    always_comb
    begin
        if (width_reg == 7'd0)
            w = CW'(1);
        else if (32'(width_reg) > MAX_COLUMNS)
            w = CW'(MAX_COLUMNS);
        else
            w = CW'(width_reg);
        if (height_reg == 6'd0)
            h = RW'(1);
        else if (32'(height_reg) > MAX_ROWS)
            h = RW'(MAX_ROWS);
        else
            h = RW'(height_reg);
    end

    logic [IW-1:0] cells;
    logic [IW-1:0] row_base;
    logic [IW-1:0] ptr_w;
    assign cells    = IW'(w) * IW'(h);
    assign row_base = IW'(row_reg) * IW'(w);
    assign ptr_w    = ptr_reg + IW'(w);

    // memory write and registered read
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [6:0]    mem_wd;
    always_ff @(posedge clk)
    begin
        if (mem_we && mem_wa < IW'(CELLS))
            mem[mem_wa[AW-1:0]] <= mem_wd;
        if (ptr_w < IW'(CELLS))
            rd_reg <= mem[ptr_w[AW-1:0]];
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = ptr_reg;
        mem_wd = CH_SPACE;
        unique case (state_reg)
            S_INIT, S_CLEAR, S_TAB, S_SCR_CLR: mem_we = 1'b1;
            S_PUT:
            begin
                mem_we = 1'b1;
                mem_wd = byte_reg;
            end
            S_SCR_WR:
            begin
                mem_we = 1'b1;
                mem_wd = rd_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    function automatic logic printable(input logic [7:0] b);
        return b >= 8'h20 && b <= 8'h7E;
    endfunction

    // address decode
    logic [IW+11:0] addr_x;
    logic [RW-1:0]  addr_row;
    assign addr_x = (IW+12)'(address);
    always_comb
    begin
        addr_row = '0;
        for (int r = 0; r < MAX_ROWS; r++)
            if (addr_x >= (IW+12)'(r * w))
                addr_row = RW'(r);
    end

    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign read_data = rdata_reg;
    assign status = status_reg;
    assign refresh_valid = upd_reg;
    assign refresh_first = upd_reg ? 5'(lo_reg) : 5'd0;
    assign refresh_last  = upd_reg ? 6'(hi_reg) : 6'd0;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            ptr_reg    <= '0;
            end_reg    <= '0;
            upd_reg    <= 1'b0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            lf_reg     <= 1'b0;
            byte_reg   <= '0;
            rdata_reg  <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data[5:0];
                col_reg <= '0;
                row_reg <= '0;
            end
            unique case (state_reg)
                S_INIT:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg == IW'(CELLS - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                    if (in_valid)
                    begin
                        upd_reg    <= 1'b0;
                        rdata_reg  <= '0;
                        status_reg <= ST_OK;
                        lf_reg     <= 1'b0;
                        byte_reg   <= data_byte[6:0];
                        state_reg  <= S_OUT;
                        if (!op)
                        begin
                            if (address == 12'd0)
                                rdata_reg <= {7'(w), 10'd0, 6'(h)};
                            else
                                status_reg <= ST_BAD_READ;
                        end
                        else if (addr_x < (IW+12)'(cells))
                        begin
                            ptr_reg  <= IW'(address);
                            byte_reg <= printable(data_byte) ? data_byte[6:0] : CH_SPACE;
                            upd_reg  <= 1'b1;
                            lo_reg   <= addr_row;
                            hi_reg   <= addr_row + 1'b1;
                            state_reg <= S_PUT;
                            lf_reg   <= 1'b1;
                        end
                        else if (addr_x == (IW+12)'(cells))
                        begin
                            state_reg <= S_DONE;
                            ptr_reg <= row_base + IW'(col_reg);
                            if (printable(data_byte))
                            begin
                                state_reg <= S_PUT;
                                upd_reg <= 1'b1;
                                lo_reg  <= row_reg;
                                hi_reg  <= row_reg + 1'b1;
                            end
                            else if (data_byte == CH_TAB)
                            begin
                                state_reg <= S_TAB;
                                upd_reg <= 1'b1;
                                lo_reg  <= row_reg;
                                hi_reg  <= row_reg + 1'b1;
                            end
                            else if (data_byte == CH_CR)
                                col_reg <= '0;
                            else if (data_byte == CH_BS)
                            begin
                                if (col_reg != '0)
                                    col_reg <= col_reg - 1'b1;
                            end
                            else if (data_byte == CH_LF)
                            begin
                                // clear rest of line, then the wrap step moves down
                                end_reg <= row_base + IW'(w);
                                col_reg <= w;
                                state_reg <= S_CLEAR;
                                lf_reg <= 1'b0;
                            end
                            else if (data_byte == CH_FF)
                            begin
                                ptr_reg <= '0;
                                end_reg <= cells;
                                col_reg <= '0;
                                row_reg <= '0;
                                upd_reg <= 1'b1;
                                lo_reg  <= '0;
                                hi_reg  <= h;
                                state_reg <= S_CLEAR;
                                lf_reg <= 1'b1;
                            end
                        end
                        else
                            status_reg <= ST_BAD_WRITE;
                    end
                S_PUT:
                begin
                    // lf_reg marks a direct cell write here
                    if (lf_reg)
                        state_reg <= S_OUT;
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_TAB:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    col_reg <= col_reg + 1'b1;
                    if (!((col_reg + 1'b1) < w && ((32'(col_reg) + 1) % TAB_STOP) != 0))
                        state_reg <= S_DONE;
                end
                S_CLEAR:
                begin
                    if (ptr_reg + 1'b1 >= end_reg)
                        state_reg <= lf_reg ? S_OUT : S_DONE;
                    ptr_reg <= ptr_reg + 1'b1;
                end
                S_DONE:
                begin
                    // wrap check after a byte; clears the new line if any, else scrolls
                    if (col_reg >= w)
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                        if (row_reg + 1'b1 < h)
                        begin
                            ptr_reg <= row_base + IW'(w);
                            end_reg <= row_base + IW'(w) + IW'(w);
                            lf_reg  <= 1'b1;
                            state_reg <= S_CLEAR;
                            if (!upd_reg || row_reg < lo_reg)
                                lo_reg <= row_reg;
                            if (!upd_reg || row_reg + 2'd2 > hi_reg)
                                hi_reg <= row_reg + 2'd2;
                            upd_reg <= 1'b1;
                        end
                        else
                            state_reg <= S_WRAP;
                    end
                    else if (row_reg >= h)
                        state_reg <= S_WRAP;
                    else
                        state_reg <= S_OUT;
                end
                S_WRAP:
                begin
                    // scroll up one row
                    row_reg <= h - 1'b1;
                    upd_reg <= 1'b1;
                    lo_reg  <= '0;
                    hi_reg  <= h;
                    ptr_reg <= '0;
                    end_reg <= cells - IW'(w);
                    state_reg <= (h == RW'(1)) ? S_SCR_CLR : S_SCR_RD;
                end
                S_SCR_RD: state_reg <= S_SCR_WR;
                S_SCR_WR:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    state_reg <= (ptr_reg + 1'b1 >= end_reg) ? S_SCR_CLR : S_SCR_RD;
                end
                S_SCR_CLR:
                begin
                    ptr_reg <= ptr_reg + 1'b1;
                    if (ptr_reg + 1'b1 >= cells)
                        state_reg <= S_OUT;
                end
                S_OUT:
                    if (out_ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/tcdb_checker.sv =====
// Port checker for the text console display buffer.
// Depends on tcdb_pkg and the top level's ports; bound to it below.
module tcdb_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic       refresh_valid,
    input logic [4:0] refresh_first,
    input logic [5:0] refresh_last
);
    import tcdb_pkg::*;

    // hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped under stall");
    // never take a request while a result waits
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready while result pending");
    // refresh range is non-empty when valid
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && refresh_valid |-> 6'(refresh_first) < refresh_last)
        else $error("empty refresh range");
    // errors report no refresh
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> !refresh_valid)
        else $error("refresh on error");
endmodule

bind text_console_display_buffer_unit tcdb_checker u_tcdb_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .refresh_valid(refresh_valid), .refresh_first(refresh_first),
    .refresh_last(refresh_last)
);
